### hdl/mexp_pkg.sv
// Shared beat types for the modular exponentiation block.
`default_nettype none
package mexp_pkg;

	typedef struct packed {
		logic [31:0] base;
		logic [31:0] exponent;
		logic [31:0] modulus;
	} req_t;

	typedef struct packed {
		logic [31:0] power_result;
		logic        bad_modulus;
	} rsp_t;

endpackage
`default_nettype wire

### hdl/mexp_mulmod.sv
// Shared modular multiplier: a registered product, then a bit-serial restoring reduction.
`default_nettype none
module mexp_mulmod #(
	parameter int WIDTH = 32
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [WIDTH-1:0] op_a,
	input  wire logic [WIDTH-1:0] op_b,
	input  wire logic [WIDTH-1:0] modulus,
	output logic                  done,
	output logic [WIDTH-1:0]      remainder
);
	localparam int PW = 2 * WIDTH;
	localparam int CW = $clog2(PW + 1);

	logic [PW-1:0]    prod_q;
	logic [WIDTH-1:0] rem_q;
	logic [CW-1:0]    cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [PW-1:0]    prod_w;
	logic [WIDTH:0]   trial;
	logic [WIDTH:0]   diff;
	logic             ge;
	logic [WIDTH-1:0] rem_next;

	assign prod_w   = {{WIDTH{1'b0}}, op_a} * {{WIDTH{1'b0}}, op_b};

	// Shift the next product bit into the partial remainder and subtract the
	// modulus when it fits; the remainder always stays below the modulus.
	assign trial    = {rem_q, prod_q[PW-1]};
	assign ge       = trial >= {1'b0, modulus};
	assign diff     = trial - {1'b0, modulus};
	assign rem_next = ge ? diff[WIDTH-1:0] : trial[WIDTH-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(PW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			prod_q <= prod_w;
			rem_q  <= '0;
		end else if (busy_q) begin
			prod_q <= {prod_q[PW-2:0], 1'b0};
			rem_q  <= rem_next;
		end
	end

	assign done      = done_q;
	assign remainder = rem_q;
endmodule
`default_nettype wire

### hdl/modular_exponentiation.sv
// Top level of the modular exponentiation block: beat handshakes and the sequencer.
//
// Each request beat carries a base, an exponent and a modulus; the low WIDTH bits of
// each are used. The block returns base to the exponent modulo the modulus, scanning
// all WIDTH exponent bits from the top: square, then multiply by the base when the
// bit is set. Every product is exact at 2*WIDTH bits and reduced by one shared unit,
// a WIDTH-by-WIDTH multiplier followed by a bit-serial restoring reduction that takes
// one product bit per cycle. An item with a nonzero exponent and modulus takes between
// WIDTH+1 and 2*WIDTH modular multiplies. A zero exponent gives 1 and a zero modulus
// gives 0 with bad_modulus set; for both the item goes straight to the hold state, its
// response beat is offered once the result is handed to the response register, and the
// next request can be taken in the same cycle as that beat is first offered. The request
// side is stalled while an item is in work; a finished result waits in the hold state
// until the response register is free and then in that register, so a new request can
// be taken while the previous response beat is still stalled.
`default_nettype none
module modular_exponentiation #(
	parameter int WIDTH = 32
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            req_valid,
	output logic                 req_stall,
	input  wire mexp_pkg::req_t  req,
	output logic                 rsp_valid,
	input  wire logic            rsp_stall,
	output mexp_pkg::rsp_t       rsp
);
	import mexp_pkg::*;

	localparam int IW = $clog2(WIDTH);

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_MUL  = 4'b0010,
		S_RED  = 4'b0100,
		S_HOLD = 4'b1000
	} state_t;

	state_t           state_q;
	logic [WIDTH-1:0] base_q;
	logic [WIDTH-1:0] exp_q;
	logic [WIDTH-1:0] mod_q;
	logic [WIDTH-1:0] acc_q;
	logic [IW-1:0]    bit_idx_q;
	logic             square_q;
	logic [WIDTH-1:0] fin_res_q;
	logic             fin_bad_q;
	rsp_t             rsp_q;
	logic             rsp_valid_q;

	logic             req_take;
	logic             rsp_take;
	logic             hand_off;
	logic             mm_start;
	logic             mm_done;
	logic [WIDTH-1:0] mm_rem;
	logic [WIDTH-1:0] mm_b;
	logic [WIDTH-1:0] in_base;
	logic [WIDTH-1:0] in_exp;
	logic [WIDTH-1:0] in_mod;

	assign in_base  = req.base[WIDTH-1:0];
	assign in_exp   = req.exponent[WIDTH-1:0];
	assign in_mod   = req.modulus[WIDTH-1:0];

	assign req_stall = (state_q != S_IDLE);
	assign req_take  = req_valid && (state_q == S_IDLE);
	assign rsp_take  = rsp_valid_q && !rsp_stall;

	// The finished result moves to the response register once that register is
	// empty or its beat is being taken in the same cycle.
	assign hand_off  = (state_q == S_HOLD) && (!rsp_valid_q || !rsp_stall);

	// The multiply operand is the accumulator itself on a squaring step and the
	// unreduced base otherwise.
	assign mm_start = (state_q == S_MUL);
	assign mm_b     = square_q ? acc_q : base_q;

	mexp_mulmod #(
		.WIDTH (WIDTH)
	) u_mulmod (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (mm_start),
		.op_a      (acc_q),
		.op_b      (mm_b),
		.modulus   (mod_q),
		.done      (mm_done),
		.remainder (mm_rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			if (hand_off) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_take) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req_take) begin
						if (in_mod == '0 || in_exp == '0) begin
							state_q <= S_HOLD;
						end else begin
							state_q <= S_MUL;
						end
					end
				end
				S_MUL: begin
					state_q <= S_RED;
				end
				S_RED: begin
					if (mm_done) begin
						if (square_q && exp_q[bit_idx_q]) begin
							state_q <= S_MUL;
						end else if (bit_idx_q == '0) begin
							state_q <= S_HOLD;
						end else begin
							state_q <= S_MUL;
						end
					end
				end
				S_HOLD: begin
					// Hand the result over once the response register is free.
					if (hand_off) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (req_take) begin
			base_q    <= in_base;
			exp_q     <= in_exp;
			mod_q     <= in_mod;
			acc_q     <= WIDTH'(1);
			bit_idx_q <= IW'(WIDTH - 1);
			square_q  <= 1'b1;
			fin_bad_q <= (in_mod == '0);
			fin_res_q <= (in_mod == '0) ? '0 : WIDTH'(1);
		end
		if (state_q == S_RED && mm_done) begin
			acc_q <= mm_rem;
			if (square_q && exp_q[bit_idx_q]) begin
				square_q <= 1'b0;
			end else begin
				square_q  <= 1'b1;
				bit_idx_q <= bit_idx_q - IW'(1);
				fin_res_q <= mm_rem;
			end
		end
		if (hand_off) begin
			rsp_q.power_result <= 32'(fin_res_q);
			rsp_q.bad_modulus  <= fin_bad_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;
endmodule
`default_nettype wire

### hdl/mexp_chk.sv
// Port-level checker for the modular exponentiation block, with its bind.
`default_nettype none
module mexp_chk (
	input wire logic           clk,
	input wire logic           arst_n,
	input wire logic           req_valid,
	input wire logic           req_stall,
	input wire logic           rsp_valid,
	input wire logic           rsp_stall,
	input wire mexp_pkg::rsp_t rsp
);
	import mexp_pkg::*;

	// A stalled response beat stays offered and unchanged.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("response beat changed while stalled");

	// A bad modulus always reports a zero result.
	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.bad_modulus |-> rsp.power_result == 32'd0)
		else $error("bad modulus with nonzero result");

	// Once a request is taken the block is busy in the next cycle.
	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("request side open right after a request beat");

	// No result can appear in the cycle right after a request is taken.
	a_no_instant_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> !$rose(rsp_valid))
		else $error("response raised too early");
endmodule

bind modular_exponentiation mexp_chk u_mexp_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_stall (req_stall),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp       (rsp)
);
`default_nettype wire
